@@ rtl/core/dcr_pkg.sv @@
// ----------------------------------------------------------------------------
// dcr_pkg
// Shared widths, register codes and pipeline word types for the distance
// constraint relaxation core.
// ----------------------------------------------------------------------------
package dcr_pkg;

    localparam int CW      = 24;                       // coordinate width
    localparam int DW      = CW + 1;                   // difference / length width
    localparam int SQ_W    = 2 * DW;                   // squared length width
    localparam int REST_W  = 23;
    localparam int RESTI_W = 17;
    localparam int TOL_W   = 23;
    localparam int ERR_W   = (DW > REST_W) ? DW : REST_W;
    localparam int P_W     = DW + ERR_W;               // |d| * |err|
    localparam int HALF    = (P_W + 1) / 2;            // split of quotient for gain mult
    localparam int PH_W    = P_W - HALF + RESTI_W;
    localparam int PL_W    = HALF + RESTI_W;
    localparam int SUM_W   = P_W + RESTI_W;
    localparam int RSH     = 16;
    localparam int C_W     = SUM_W - RSH;
    localparam int N_W     = CW + 4;                   // corrected coordinate before clamp

    localparam int SQRT_LAT = DW;
    localparam int DIV_LAT  = P_W;

    localparam int TDATA_W = ((4 * CW + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = REST_W;

    localparam logic [CFG_IDX_W-1:0] CFG_REST_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTITUTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 2'd2;

    localparam logic [REST_W-1:0]  REST_RESET  = 23'd25600;
    localparam logic [RESTI_W-1:0] RESTI_RESET = 17'd32768;
    localparam logic [TOL_W-1:0]   TOL_RESET   = 23'd128;

    // beyond this magnitude every corrected coordinate saturates anyway
    localparam logic [DW:0] CORR_CLAMP = {1'b1, {DW{1'b0}}};

    typedef enum logic [1:0] {
        ST_WITHIN     = 2'd0,
        ST_ADJUSTED   = 2'd1,
        ST_DEGENERATE = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic [DW-1:0]        dxm;
        logic [DW-1:0]        dym;
        logic                 sx;
        logic                 sy;
        logic                 degen;
        logic                 serr;
        logic                 adj;
        logic [ERR_W-1:0]     emag;
    } t_item;

endpackage

@@ rtl/core/distance_constraint_relax_core.sv @@
// ----------------------------------------------------------------------------
// distance_constraint_relax_core
// One relaxation step of a distance constraint: length by square root,
// correction scaled by (1 - rest/len) * restitution, applied to both ends.
//
//   channel   dir  handshake                  payload
//   s_axis    in   i_s_axis_tvalid/o_..tready  tdata: first_x, first_y,
//                                              second_x, second_y
//   m_axis    out  o_m_axis_tvalid/i_..tready  tdata: new coords, tuser: status
//   cfg       in   i_cfg_valid/o_cfg_ready     index, data
//
// One word per cycle sustained while the output is taken. The square root and
// the two dividers are bit-per-stage pipelines. Reset is synchronous and clears
// the valid bits and the configuration registers, not the datapath registers.
// The whole pipeline holds only while its last stage and the output register
// both hold words that are not taken.
// ----------------------------------------------------------------------------
module distance_constraint_relax_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // first_x, first_y, second_x, second_y
    input  logic [dcr_pkg::TDATA_W-1:0]      i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // new_first_x, new_first_y, new_second_x, new_second_y
    output logic [dcr_pkg::TDATA_W-1:0]      o_m_axis_tdata,
    // status
    output logic [1:0]                       o_m_axis_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dcr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dcr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import dcr_pkg::*;

    function automatic logic signed [CW-1:0] sat_c(input logic signed [N_W-1:0] v);
        logic same;
        same = (&v[N_W-1:CW-1]) || !(|v[N_W-1:CW-1]);
        if (same) begin
            return v[CW-1:0];
        end
        return v[N_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endfunction

    // configuration
    logic [REST_W-1:0]  r_rest;
    logic [RESTI_W-1:0] r_resti;
    logic [TOL_W-1:0]   r_tol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest  <= REST_RESET;
            r_resti <= RESTI_RESET;
            r_tol   <= TOL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REST_LENGTH: r_rest  <= i_cfg_data[REST_W-1:0];
                CFG_RESTITUTION: r_resti <= i_cfg_data[RESTI_W-1:0];
                CFG_TOLERANCE:   r_tol   <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_ov;
    logic r_sv [0:SQRT_LAT-1];
    logic r_dv [0:DIV_LAT-1];
    logic out_ready;
    logic en;

    assign out_ready       = !r_ov || i_m_axis_tready;
    assign en              = !r_v8 || out_ready;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0; r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_v5 <= 1'b0; r_v6 <= 1'b0; r_v7 <= 1'b0; r_v8 <= 1'b0;
            for (int i = 0; i < SQRT_LAT; i++) r_sv[i] <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++)  r_dv[i] <= 1'b0;
        end else if (en) begin
            r_v0 <= i_s_axis_tvalid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_sv[0] <= r_v3;
            for (int i = 1; i < SQRT_LAT; i++) r_sv[i] <= r_sv[i-1];
            r_v4 <= r_sv[SQRT_LAT-1];
            r_v5 <= r_v4;
            r_dv[0] <= r_v5;
            for (int i = 1; i < DIV_LAT; i++) r_dv[i] <= r_dv[i-1];
            r_v6 <= r_dv[DIV_LAT-1];
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    // datapath registers
    t_item r_i0, r_i1, r_i2, r_i3, r_i4, r_i5, r_i6, r_i7;
    t_item r_si [0:SQRT_LAT-1];
    t_item r_di [0:DIV_LAT-1];
    logic [SQ_W-1:0]  r_sqx, r_sqy, r_sq;
    logic [DW-1:0]    r_len4, r_len5;
    logic [P_W-1:0]   r_px, r_py;
    logic [PH_W-1:0]  r_phx, r_phy;
    logic [PL_W-1:0]  r_plx, r_ply;
    logic [DW:0]      r_cx, r_cy;
    logic signed [CW-1:0] r_nax, r_nay, r_nbx, r_nby;
    t_status          r_st8;
    logic [TDATA_W-1:0] r_od;
    t_status          r_ost;

    logic [DW-1:0]  w_root;
    logic [P_W-1:0] w_qx, w_qy;

    // stage 0: unpack
    t_item c_in;
    always_comb begin
        c_in    = '0;
        c_in.ax = i_s_axis_tdata[CW-1:0];
        c_in.ay = i_s_axis_tdata[2*CW-1:CW];
        c_in.bx = i_s_axis_tdata[3*CW-1:2*CW];
        c_in.by = i_s_axis_tdata[4*CW-1:3*CW];
    end

    // stage 1: difference and magnitudes
    logic signed [DW-1:0] c_dx, c_dy;
    t_item c_i1;
    always_comb begin
        c_dx        = DW'(r_i0.ax) - DW'(r_i0.bx);
        c_dy        = DW'(r_i0.ay) - DW'(r_i0.by);
        c_i1        = r_i0;
        c_i1.sx     = c_dx[DW-1];
        c_i1.sy     = c_dy[DW-1];
        c_i1.dxm    = c_dx[DW-1] ? $unsigned(-c_dx) : $unsigned(c_dx);
        c_i1.dym    = c_dy[DW-1] ? $unsigned(-c_dy) : $unsigned(c_dy);
        c_i1.degen  = (c_dx == '0) && (c_dy == '0);
    end

    // stage 4: length error against rest length
    logic signed [ERR_W:0] c_err;
    t_item c_i4;
    always_comb begin
        c_err     = $signed({1'b0, ERR_W'(w_root)}) - $signed({1'b0, ERR_W'(r_rest)});
        c_i4      = r_si[SQRT_LAT-1];
        c_i4.serr = c_err[ERR_W];
        c_i4.emag = c_err[ERR_W] ? ERR_W'($unsigned(-c_err)) : ERR_W'($unsigned(c_err));
        c_i4.adj  = !c_i4.degen && (c_i4.emag > ERR_W'(r_tol));
    end

    // stage 7: gain product, shift and clamp
    logic [SUM_W-1:0] c_sumx, c_sumy;
    logic [C_W-1:0]   c_cx, c_cy;
    logic [DW:0]      c_mx, c_my;
    always_comb begin
        c_sumx = (SUM_W'(r_phx) << HALF) + SUM_W'(r_plx);
        c_sumy = (SUM_W'(r_phy) << HALF) + SUM_W'(r_ply);
        c_cx   = c_sumx[SUM_W-1:RSH];
        c_cy   = c_sumy[SUM_W-1:RSH];
        c_mx   = (c_cx > C_W'(CORR_CLAMP)) ? CORR_CLAMP : c_cx[DW:0];
        c_my   = (c_cy > C_W'(CORR_CLAMP)) ? CORR_CLAMP : c_cy[DW:0];
    end

    // stage 8: apply correction with saturation
    logic signed [N_W-1:0] c_mx_s, c_my_s, c_csx, c_csy;
    t_status c_st;
    always_comb begin
        c_mx_s = N_W'($signed({1'b0, r_cx}));
        c_my_s = N_W'($signed({1'b0, r_cy}));
        c_csx  = (r_i7.sx ^ r_i7.serr) ? -c_mx_s : c_mx_s;
        c_csy  = (r_i7.sy ^ r_i7.serr) ? -c_my_s : c_my_s;
        priority if (r_i7.degen) begin
            c_st = ST_DEGENERATE;
        end else if (r_i7.adj) begin
            c_st = ST_ADJUSTED;
        end else begin
            c_st = ST_WITHIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i0  <= c_in;
            r_i1  <= c_i1;
            r_i2  <= r_i1;
            r_sqx <= r_i1.dxm * r_i1.dxm;
            r_sqy <= r_i1.dym * r_i1.dym;
            r_i3  <= r_i2;
            r_sq  <= r_sqx + r_sqy;
            r_si[0] <= r_i3;
            for (int i = 1; i < SQRT_LAT; i++) r_si[i] <= r_si[i-1];
            r_i4   <= c_i4;
            r_len4 <= w_root;
            r_i5   <= r_i4;
            r_len5 <= r_len4;
            r_px   <= r_i4.dxm * r_i4.emag;
            r_py   <= r_i4.dym * r_i4.emag;
            r_di[0] <= r_i5;
            for (int i = 1; i < DIV_LAT; i++) r_di[i] <= r_di[i-1];
            r_i6  <= r_di[DIV_LAT-1];
            r_phx <= w_qx[P_W-1:HALF] * r_resti;
            r_plx <= w_qx[HALF-1:0] * r_resti;
            r_phy <= w_qy[P_W-1:HALF] * r_resti;
            r_ply <= w_qy[HALF-1:0] * r_resti;
            r_i7  <= r_i6;
            r_cx  <= r_i6.adj ? c_mx : '0;
            r_cy  <= r_i6.adj ? c_my : '0;
            r_nax <= sat_c(N_W'(r_i7.ax) - c_csx);
            r_nay <= sat_c(N_W'(r_i7.ay) - c_csy);
            r_nbx <= sat_c(N_W'(r_i7.bx) + c_csx);
            r_nby <= sat_c(N_W'(r_i7.by) + c_csy);
            r_st8 <= c_st;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_ready) begin
            r_ov <= r_v8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_od  <= TDATA_W'({r_nby, r_nbx, r_nay, r_nax});
            r_ost <= r_st8;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_od;
    assign o_m_axis_tuser  = r_ost;

    dcr_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_n    (r_sq),
        .o_root (w_root)
    );

    dcr_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_px),
        .i_den  (r_len5),
        .o_quot (w_qx)
    );

    dcr_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_py),
        .i_den  (r_len5),
        .o_quot (w_qy)
    );

    // a non-coincident word never leaves the root with zero length
    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv[SQRT_LAT-1] && !r_si[SQRT_LAT-1].degen |-> w_root != '0)
        else $error("zero length for non-coincident points");

    // coincident points are never marked for correction
    a_degen_no_adj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r_i4.degen |-> !r_i4.adj)
        else $error("degenerate word marked adjusted");

    // no correction leaves the gain stage for a word within tolerance
    a_zero_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_v6 && !r_i6.adj |=> r_cx == '0 && r_cy == '0)
        else $error("correction on unadjusted word");

    // a held pipeline keeps its last stage
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v8) && $stable(r_nax) && $stable(r_st8))
        else $error("last stage changed during hold");

endmodule

@@ rtl/core/dcr_isqrt.sv @@
// ----------------------------------------------------------------------------
// dcr_isqrt
// Pipelined integer square root, floor, one result bit per stage.
// ----------------------------------------------------------------------------
module dcr_isqrt (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [dcr_pkg::SQ_W-1:0] i_n,
    output logic [dcr_pkg::DW-1:0]   o_root
);
    import dcr_pkg::*;

    localparam int R_W = DW + 3;

    logic [R_W-1:0]  r_rem  [0:DW-2];
    logic [SQ_W-1:0] r_n    [0:DW-2];
    logic [DW-1:0]   r_root [0:DW-1];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [R_W-1:0]  rin;
        logic [DW-1:0]   qin;
        logic [SQ_W-1:0] nin;
        logic [R_W-1:0]  rsh;
        logic [R_W-1:0]  trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign rin = '0;
            assign qin = '0;
            assign nin = i_n;
        end else begin : g_next
            assign rin = r_rem[k-1];
            assign qin = r_root[k-1];
            assign nin = r_n[k-1];
        end

        assign rsh   = {rin[R_W-3:0], nin[SQ_W-1 -: 2]};
        assign trial = R_W'({qin, 2'b01});
        assign ge    = (rsh >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= {qin[DW-2:0], ge};
            end
        end

        if (k < DW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? (rsh - trial) : rsh;
                    r_n[k]   <= {nin[SQ_W-3:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[DW-1];

endmodule

@@ rtl/core/dcr_div.sv @@
// ----------------------------------------------------------------------------
// dcr_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module dcr_div (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [dcr_pkg::P_W-1:0] i_num,
    input  logic [dcr_pkg::DW-1:0]  i_den,
    output logic [dcr_pkg::P_W-1:0] o_quot
);
    import dcr_pkg::*;

    // dividend shifts out the top while quotient bits shift in below
    logic [P_W-1:0] r_dq  [0:P_W-1];
    logic [DW-1:0]  r_rem [0:P_W-2];
    logic [DW-1:0]  r_den [0:P_W-2];

    for (genvar k = 0; k < P_W; k++) begin : g_stage
        logic [DW-1:0]  rin;
        logic [DW-1:0]  din;
        logic [P_W-1:0] qin;
        logic [DW:0]    rsh;
        logic [DW:0]    rsub;
        logic           ge;

        if (k == 0) begin : g_first
            assign rin = '0;
            assign din = i_den;
            assign qin = i_num;
        end else begin : g_next
            assign rin = r_rem[k-1];
            assign din = r_den[k-1];
            assign qin = r_dq[k-1];
        end

        assign rsh  = {rin, qin[P_W-1]};
        assign ge   = (rsh >= {1'b0, din});
        assign rsub = rsh - {1'b0, din};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dq[k] <= {qin[P_W-2:0], ge};
            end
        end

        if (k < P_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? rsub[DW-1:0] : rsh[DW-1:0];
                    r_den[k] <= din;
                end
            end
        end
    end

    assign o_quot = r_dq[P_W-1];

endmodule
